@@ rtl/sqfe_pkg.sv @@
`default_nettype none
package sqfe_pkg;
    localparam int MAX_STARS      = 64;
    localparam int COORD_BITS     = 16;
    localparam int IDX_W          = $clog2(MAX_STARS);
    localparam int CNT_W          = IDX_W + 1;
    localparam int NEIGHBORS      = 3;
    localparam int LENGTHS        = 6;
    localparam int LEN_FRAC_SHIFT = 12;
    localparam int ABS_W          = COORD_BITS;
    localparam int SQ_W           = 2 * COORD_BITS;
    localparam int DIST_W         = SQ_W + 1;
    localparam int RT_W           = (DIST_W + LEN_FRAC_SHIFT + 1) / 2;
    localparam int RATIO_W        = 17;
    localparam int RATIO_FRAC     = 16;
    localparam int DIV_N          = RT_W + RATIO_FRAC;
    localparam int STEP_W         = $clog2(DIV_N + 1);
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int MIN_STARS      = 4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Slot 0 holds the star itself, slots 1 to 3 its neighbors in rank order.
    typedef struct packed {
        logic [3:0][COORD_BITS-1:0] x;
        logic [3:0][COORD_BITS-1:0] y;
        logic [IDX_W-1:0]           idx;
        logic                       last;
        logic                       ovf;
        logic                       few;
    } t_rec;

    function automatic logic [1:0] pair_a(input logic [2:0] k);
        case (k)
            3'd0:    pair_a = 2'd0;
            3'd1:    pair_a = 2'd0;
            3'd2:    pair_a = 2'd0;
            3'd3:    pair_a = 2'd1;
            3'd4:    pair_a = 2'd2;
            3'd5:    pair_a = 2'd3;
            default: pair_a = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] k);
        case (k)
            3'd0:    pair_b = 2'd1;
            3'd1:    pair_b = 2'd2;
            3'd2:    pair_b = 2'd3;
            3'd3:    pair_b = 2'd2;
            3'd4:    pair_b = 2'd3;
            3'd5:    pair_b = 2'd1;
            default: pair_b = 2'd0;
        endcase
    endfunction

    function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        abs_diff = m[ABS_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/sqfe_front.sv @@
`default_nettype none
module sqfe_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [15:0]                   i_x,
    input  wire [15:0]                   i_y,
    input  wire                          i_last,
    output logic                         o_busy,
    input  wire                          i_full,
    output logic                         o_push,
    output sqfe_pkg::t_rec               o_rec
);
    import sqfe_pkg::*;

    typedef enum logic [7:0] {
        F_LOAD  = 8'b0000_0001,
        F_RDI   = 8'b0000_0010,
        F_WAITI = 8'b0000_0100,
        F_SCAN  = 8'b0000_1000,
        F_DRAIN = 8'b0001_0000,
        F_FETCH = 8'b0010_0000,
        F_PUSH  = 8'b0100_0000,
        F_FEW   = 8'b1000_0000
    } t_fstate;

    logic [COORD_BITS-1:0] r_mem_x [MAX_STARS];
    logic [COORD_BITS-1:0] r_mem_y [MAX_STARS];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;

    t_fstate               r_state, n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_ovf;
    logic [IDX_W-1:0]      r_i;
    logic [CNT_W-1:0]      r_j;
    logic [COORD_BITS-1:0] r_cix, r_ciy;

    logic                  r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]      r_j1, r_j2, r_j3;
    logic [ABS_W-1:0]      r_ax, r_ay;
    logic [SQ_W-1:0]       r_px, r_py;

    logic [2:0][DIST_W-1:0] r_bd, n_bd;
    logic [2:0][IDX_W-1:0]  r_bi, n_bi;
    logic [1:0]             r_filled, n_filled;

    logic [1:0]                 r_fk;
    logic                       r_fv;
    logic [1:0]                 r_fkd;
    logic [2:0][COORD_BITS-1:0] r_nx, r_ny;

    logic                  w_room;
    logic [CNT_W-1:0]      w_cnt_after;
    logic                  w_accept;
    logic [IDX_W-1:0]      w_raddr;
    logic [DIST_W-1:0]     w_d;
    logic                  w_issue;
    logic                  w_last_star;

    assign o_busy      = (r_state != F_LOAD);
    assign w_accept    = i_start && (r_state == F_LOAD);
    assign w_room      = (r_cnt < CNT_W'(MAX_STARS));
    assign w_cnt_after = w_room ? r_cnt + 1'b1 : r_cnt;
    assign w_issue     = (r_state == F_SCAN) && (r_j < r_cnt);
    assign w_last_star = ({1'b0, r_i} == r_cnt - 1'b1);
    assign w_d         = DIST_W'(r_px) + DIST_W'(r_py);

    always_comb begin
        case (r_state)
            F_RDI:   w_raddr = r_i;
            F_SCAN:  w_raddr = r_j[IDX_W-1:0];
            F_FETCH: w_raddr = r_bi[r_fk];
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_mem_x[r_cnt[IDX_W-1:0]] <= i_x[COORD_BITS-1:0];
            r_mem_y[r_cnt[IDX_W-1:0]] <= i_y[COORD_BITS-1:0];
        end
        r_rd_x <= r_mem_x[w_raddr];
        r_rd_y <= r_mem_y[w_raddr];
    end

    // Keep the three smallest distances; a tie never displaces an earlier index.
    always_comb begin
        n_bd     = r_bd;
        n_bi     = r_bi;
        n_filled = r_filled;
        if (r_v3) begin
            if (r_filled > 2'd0 && w_d < r_bd[0]) begin
                n_bd[2] = r_bd[1]; n_bi[2] = r_bi[1];
                n_bd[1] = r_bd[0]; n_bi[1] = r_bi[0];
                n_bd[0] = w_d;     n_bi[0] = r_j3;
            end else if (r_filled > 2'd1 && w_d < r_bd[1]) begin
                n_bd[2] = r_bd[1]; n_bi[2] = r_bi[1];
                n_bd[1] = w_d;     n_bi[1] = r_j3;
            end else if (r_filled > 2'd2 && w_d < r_bd[2]) begin
                n_bd[2] = w_d;     n_bi[2] = r_j3;
            end else if (r_filled < 2'd3) begin
                n_bd[r_filled] = w_d;
                n_bi[r_filled] = r_j3;
            end
            if (r_filled < 2'd3) begin
                n_filled = r_filled + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = (w_cnt_after < CNT_W'(MIN_STARS)) ? F_FEW : F_RDI;
                end
            end
            F_RDI:   n_state = F_WAITI;
            F_WAITI: n_state = F_SCAN;
            F_SCAN: begin
                if (!w_issue) begin
                    n_state = F_DRAIN;
                end
            end
            F_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = F_FETCH;
                end
            end
            F_FETCH: begin
                if (r_fk == 2'd2) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!r_fv && !i_full) begin
                    o_push  = 1'b1;
                    n_state = w_last_star ? F_LOAD : F_RDI;
                end
            end
            F_FEW: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_LOAD;
                end
            end
            default: n_state = F_LOAD;
        endcase
    end

    always_comb begin
        o_rec      = '0;
        o_rec.x    = {r_nx[2], r_nx[1], r_nx[0], r_cix};
        o_rec.y    = {r_ny[2], r_ny[1], r_ny[0], r_ciy};
        o_rec.idx  = r_i;
        o_rec.last = w_last_star;
        o_rec.ovf  = r_ovf;
        o_rec.few  = (r_state == F_FEW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_filled <= '0;
            r_fk     <= '0;
            r_fv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_v1     <= w_issue && (r_j[IDX_W-1:0] != r_i);
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_filled <= (r_state == F_RDI) ? 2'd0 : n_filled;
            r_fv     <= (r_state == F_FETCH);
            if (w_accept) begin
                if (w_room) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
                r_i <= '0;
            end
            if (r_state == F_RDI) begin
                r_j <= '0;
            end
            if (w_issue) begin
                r_j <= r_j + 1'b1;
            end
            if (r_state == F_DRAIN) begin
                r_fk <= '0;
            end
            if (r_state == F_FETCH) begin
                r_fk <= r_fk + 1'b1;
            end
            if (o_push) begin
                if (r_state == F_FEW || w_last_star) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_WAITI) begin
            r_cix <= r_rd_x;
            r_ciy <= r_rd_y;
        end
        r_j1 <= r_j[IDX_W-1:0];
        r_j2 <= r_j1;
        r_j3 <= r_j2;
        r_ax <= abs_diff(r_rd_x, r_cix);
        r_ay <= abs_diff(r_rd_y, r_ciy);
        r_px <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_py <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_bd <= n_bd;
        r_bi <= n_bi;
        r_fkd <= r_fk;
        if (r_fv) begin
            r_nx[r_fkd] <= r_rd_x;
            r_ny[r_fkd] <= r_rd_y;
        end
    end
endmodule
`default_nettype wire

@@ rtl/sqfe_fifo.sv @@
`default_nettype none
module sqfe_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  sqfe_pkg::t_rec  i_din,
    output logic            o_full,
    input  wire             i_pop,
    output sqfe_pkg::t_rec  o_dout,
    output logic            o_empty
);
    import sqfe_pkg::*;

    t_rec               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_level;

    assign o_full  = (r_level == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_dout  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_level <= r_level + (FIFO_AW + 1)'(i_push && !o_full)
                               - (FIFO_AW + 1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

@@ rtl/sqfe_back.sv @@
`default_nettype none
module sqfe_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  sqfe_pkg::t_rec  i_rec,
    output logic            o_pop,
    output logic            o_valid,
    output logic [5:0]      o_star_index,
    output logic [16:0]     o_len_star_n0,
    output logic [16:0]     o_len_star_n1,
    output logic [16:0]     o_len_star_n2,
    output logic [16:0]     o_len_n0_n1,
    output logic [16:0]     o_len_n1_n2,
    output logic [16:0]     o_len_n2_n0,
    output logic [1:0]      o_status,
    output logic            o_last_feature
);
    import sqfe_pkg::*;

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_DIFF = 8'b0000_0010,
        B_MUL  = 8'b0000_0100,
        B_SUM  = 8'b0000_1000,
        B_SQRT = 8'b0001_0000,
        B_CHK  = 8'b0010_0000,
        B_DIV  = 8'b0100_0000,
        B_OUT  = 8'b1000_0000
    } t_bstate;

    t_bstate            r_state;
    t_rec               r_rec;
    logic [2:0]         r_k;
    logic [STEP_W-1:0]  r_step;
    logic [ABS_W-1:0]   r_ax, r_ay;
    logic [SQ_W-1:0]    r_px, r_py;
    logic [2*RT_W-1:0]  r_val;
    logic [RT_W+1:0]    r_rem;
    logic [RT_W-1:0]    r_root;
    logic [RT_W-1:0]    r_len [LENGTHS];
    logic [RT_W-1:0]    r_longest;
    logic [DIV_N-1:0]   r_num;
    logic [RT_W-1:0]    r_drem;
    logic [RATIO_W-1:0] r_q;
    logic [RATIO_W-1:0] r_ratio [LENGTHS];
    logic [1:0]         r_stat;

    logic [1:0]         w_a, w_b;
    logic [RT_W+1:0]    w_srem, w_trial;
    logic [RT_W:0]      w_drem;
    logic [RT_W:0]      w_dsub;
    logic [RT_W-1:0]    w_root_next;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign w_a     = pair_a(r_k);
    assign w_b     = pair_b(r_k);
    // One step of the integer square root: a radix-4 digit of the radicand in, one root bit out.
    assign w_srem  = {r_rem[RT_W-1:0], r_val[2*RT_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_root_next = (w_srem >= w_trial) ? {r_root[RT_W-2:0], 1'b1}
                                             : {r_root[RT_W-2:0], 1'b0};
    // One quotient bit of the restoring divider per cycle.
    assign w_drem  = {r_drem, r_num[DIV_N-1]};
    assign w_dsub  = w_drem - {1'b0, r_longest};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == B_OUT);
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_rec.few ? B_OUT : B_DIFF;
                    end
                end
                B_DIFF: r_state <= B_MUL;
                B_MUL:  r_state <= B_SUM;
                B_SUM:  r_state <= B_SQRT;
                B_SQRT: begin
                    if (r_step == STEP_W'(RT_W - 1)) begin
                        r_state <= (r_k == 3'(LENGTHS - 1)) ? B_CHK : B_DIFF;
                    end
                end
                B_CHK: begin
                    r_state <= (r_longest == '0) ? B_OUT : B_DIV;
                end
                B_DIV: begin
                    if (r_step == STEP_W'(DIV_N - 1) && r_k == 3'(LENGTHS - 1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_rec     <= i_rec;
                r_k       <= '0;
                r_longest <= '0;
                if (i_rec.few) begin
                    r_stat <= ST_FEW;
                    for (int m = 0; m < LENGTHS; m++) begin
                        r_ratio[m] <= '0;
                    end
                end
            end
            B_DIFF: begin
                r_ax <= abs_diff(r_rec.x[w_a], r_rec.x[w_b]);
                r_ay <= abs_diff(r_rec.y[w_a], r_rec.y[w_b]);
            end
            B_MUL: begin
                r_px <= SQ_W'(r_ax) * SQ_W'(r_ax);
                r_py <= SQ_W'(r_ay) * SQ_W'(r_ay);
            end
            B_SUM: begin
                r_val  <= (2*RT_W)'({DIST_W'(r_px) + DIST_W'(r_py),
                                     {LEN_FRAC_SHIFT{1'b0}}});
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            B_SQRT: begin
                r_val  <= {r_val[2*RT_W-3:0], 2'b00};
                r_root <= w_root_next;
                r_rem  <= (w_srem >= w_trial) ? w_srem - w_trial : w_srem;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(RT_W - 1)) begin
                    r_len[r_k] <= w_root_next;
                    if (w_root_next > r_longest) begin
                        r_longest <= w_root_next;
                    end
                    r_k <= (r_k == 3'(LENGTHS - 1)) ? 3'd0 : r_k + 1'b1;
                end
            end
            B_CHK: begin
                r_num  <= {r_len[0], {RATIO_FRAC{1'b0}}};
                r_drem <= '0;
                r_q    <= '0;
                r_step <= '0;
                if (r_longest == '0) begin
                    r_stat <= ST_ZERO;
                    for (int m = 0; m < LENGTHS; m++) begin
                        r_ratio[m] <= '0;
                    end
                end else begin
                    r_stat <= r_rec.ovf ? ST_OVF : ST_OK;
                end
            end
            B_DIV: begin
                if (r_step == STEP_W'(DIV_N - 1)) begin
                    r_ratio[r_k] <= {r_q[RATIO_W-2:0], (w_drem >= {1'b0, r_longest})};
                    r_k    <= r_k + 1'b1;
                    r_step <= '0;
                    r_drem <= '0;
                    r_q    <= '0;
                    if (r_k != 3'(LENGTHS - 1)) begin
                        r_num <= {r_len[r_k + 1'b1], {RATIO_FRAC{1'b0}}};
                    end
                end else begin
                    if (w_drem >= {1'b0, r_longest}) begin
                        r_drem <= w_dsub[RT_W-1:0];
                    end else begin
                        r_drem <= w_drem[RT_W-1:0];
                    end
                    r_q    <= {r_q[RATIO_W-2:0], (w_drem >= {1'b0, r_longest})};
                    r_num  <= {r_num[DIV_N-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                end
            end
            B_OUT: begin
                o_star_index   <= r_rec.few ? 6'd0 : 6'(r_rec.idx);
                o_len_star_n0  <= r_ratio[0];
                o_len_star_n1  <= r_ratio[1];
                o_len_star_n2  <= r_ratio[2];
                o_len_n0_n1    <= r_ratio[3];
                o_len_n1_n2    <= r_ratio[4];
                o_len_n2_n0    <= r_ratio[5];
                o_status       <= r_stat;
                o_last_feature <= r_rec.few | r_rec.last;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/star_quad_feature_extract.sv @@
// Star quad feature extractor.
// Centroids enter on the command port: one request is taken at each clock edge
// where start is high and busy is low. Requests are stored in load order; the
// request with i_last_centroid high closes the frame and busy rises while the
// front end scans the store. For each star the front end reads every stored
// centroid once, one per cycle, keeping the three nearest, then fetches the
// neighbor coordinates. A four-entry queue passes each star and its neighbors
// to the back end, which computes six squared distances, takes their square
// roots on a radix-4 unit (one radicand digit per cycle) and divides by the
// longest on a restoring divider (one quotient bit per cycle). The back end
// sets the sustained rate; busy falls once the front end has queued the last
// star, so the next frame may load while results still drain.
// Each result is shown for one cycle with o_valid high; the receiver cannot
// stall. A frame of fewer than four stars gives one result with status 1.
// Reset clears the star count, the overflow flag, the queue and all control
// state; no clearing pass is needed.
`default_nettype none
module star_quad_feature_extract (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [15:0]  i_centroid_x,
    input  wire [15:0]  i_centroid_y,
    input  wire         i_last_centroid,
    output logic        o_valid,
    output logic [5:0]  o_star_index,
    output logic [16:0] o_len_star_n0,
    output logic [16:0] o_len_star_n1,
    output logic [16:0] o_len_star_n2,
    output logic [16:0] o_len_n0_n1,
    output logic [16:0] o_len_n1_n2,
    output logic [16:0] o_len_n2_n0,
    output logic [1:0]  o_status,
    output logic        o_last_feature
);
    import sqfe_pkg::*;

    t_rec w_push_rec, w_pop_rec;
    logic w_push, w_pop, w_full, w_empty;

    sqfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (i_centroid_x),
        .i_y     (i_centroid_y),
        .i_last  (i_last_centroid),
        .o_busy  (busy),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    sqfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_push_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_dout  (w_pop_rec),
        .o_empty (w_empty)
    );

    sqfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_rec          (w_pop_rec),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_star_index   (o_star_index),
        .o_len_star_n0  (o_len_star_n0),
        .o_len_star_n1  (o_len_star_n1),
        .o_len_star_n2  (o_len_star_n2),
        .o_len_n0_n1    (o_len_n0_n1),
        .o_len_n1_n2    (o_len_n1_n2),
        .o_len_n2_n0    (o_len_n2_n0),
        .o_status       (o_status),
        .o_last_feature (o_last_feature)
    );

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back end emitted two results in adjacent cycles");

    a_few_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FEW) |-> (o_last_feature && o_star_index == 6'd0))
        else $error("short frame result is not a lone final result");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ZERO) |->
        (o_len_star_n0 == '0 && o_len_star_n1 == '0 && o_len_star_n2 == '0 &&
         o_len_n0_n1 == '0 && o_len_n1_n2 == '0 && o_len_n2_n0 == '0))
        else $error("zero longest length with nonzero ratios");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("front end pushed into a full queue");
endmodule
`default_nettype wire

@@ tb/tb_star_quad_feature_extract.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_star_quad_feature_extract;
    import sqfe_pkg::*;

    typedef struct {
        logic [5:0]  idx;
        logic [16:0] len [6];
        logic [1:0]  status;
        logic        last;
    } t_feature;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_centroid_x;
    logic [15:0] i_centroid_y;
    logic        i_last_centroid;
    logic        o_valid;
    logic [5:0]  o_star_index;
    logic [16:0] o_len_star_n0, o_len_star_n1, o_len_star_n2;
    logic [16:0] o_len_n0_n1, o_len_n1_n2, o_len_n2_n0;
    logic [1:0]  o_status;
    logic        o_last_feature;

    star_quad_feature_extract dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_centroid_x(i_centroid_x), .i_centroid_y(i_centroid_y),
        .i_last_centroid(i_last_centroid), .o_valid(o_valid),
        .o_star_index(o_star_index), .o_len_star_n0(o_len_star_n0),
        .o_len_star_n1(o_len_star_n1), .o_len_star_n2(o_len_star_n2),
        .o_len_n0_n1(o_len_n0_n1), .o_len_n1_n2(o_len_n1_n2),
        .o_len_n2_n0(o_len_n2_n0), .o_status(o_status),
        .o_last_feature(o_last_feature)
    );

    // Model of the star store and frame state.
    logic signed [15:0] star_x [MAX_STARS];
    logic signed [15:0] star_y [MAX_STARS];
    int                 held_stars;
    bit                 dropped_star;
    t_feature           pending_features [$];
    int                 idle_pct;
    int                 errors;
    longint             cycle_count;
    int                 pair_first [6] = '{0, 0, 0, 1, 2, 3};
    int                 pair_second [6] = '{1, 2, 3, 2, 3, 1};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned sq_dist(int a, int b);
        longint dx, dy;
        dx = longint'(star_x[a]) - longint'(star_x[b]);
        dy = longint'(star_y[a]) - longint'(star_y[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    task automatic predict_frame();
        t_feature        f;
        int              nb [4];
        longint unsigned bd [3];
        longint unsigned d, longest, r;
        longint unsigned lens [6];
        int              filled, p;
        if (held_stars < MIN_STARS) begin
            f.idx = 0;
            foreach (f.len[k]) f.len[k] = 0;
            f.status = ST_FEW;
            f.last = 1'b1;
            pending_features.push_back(f);
        end else begin
            for (int i = 0; i < held_stars; i++) begin
                filled = 0;
                nb = '{i, 0, 0, 0};
                bd = '{0, 0, 0};
                for (int j = 0; j < held_stars; j++) begin
                    if (j == i) continue;
                    d = sq_dist(i, j);
                    p = filled;
                    while (p > 0 && d < bd[p-1]) begin
                        if (p < 3) begin
                            bd[p] = bd[p-1];
                            nb[p+1] = nb[p];
                        end
                        p--;
                    end
                    if (p < 3) begin
                        bd[p] = d;
                        nb[p+1] = j;
                    end
                    if (filled < 3) filled++;
                end
                longest = 0;
                for (int k = 0; k < 6; k++) begin
                    lens[k] = int_sqrt(sq_dist(nb[pair_first[k]], nb[pair_second[k]])
                                       << LEN_FRAC_SHIFT);
                    if (lens[k] > longest) longest = lens[k];
                end
                f.idx = i[5:0];
                f.last = (i + 1 == held_stars);
                if (longest == 0) begin
                    f.status = ST_ZERO;
                    foreach (f.len[k]) f.len[k] = 0;
                end else begin
                    f.status = dropped_star ? ST_OVF : ST_OK;
                    for (int k = 0; k < 6; k++) begin
                        r = (lens[k] << 16) / longest;
                        f.len[k] = (r > 65536) ? 17'd65536 : r[16:0];
                    end
                end
                pending_features.push_back(f);
            end
        end
        held_stars = 0;
        dropped_star = 0;
    endtask

    // Start stays high from one request to the next; it drops only while idling.
    task automatic send_centroid(logic [15:0] x, logic [15:0] y, logic last);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_centroid_x <= x;
        i_centroid_y <= y;
        i_last_centroid <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (held_stars < MAX_STARS) begin
            star_x[held_stars] = x;
            star_y[held_stars] = y;
            held_stars++;
        end else begin
            dropped_star = 1;
        end
        if (last) predict_frame();
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_feature e;
        logic [16:0] got [6];
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            got = '{o_len_star_n0, o_len_star_n1, o_len_star_n2,
                    o_len_n0_n1, o_len_n1_n2, o_len_n2_n0};
            if (pending_features.size() == 0) begin
                $display("%0t unexpected request result: index %0d", $time, o_star_index);
                errors++;
            end else begin
                e = pending_features.pop_front();
                if (o_star_index !== e.idx) begin
                    $display("%0t index exp %0d got %0d", $time, e.idx, o_star_index);
                    errors++;
                end
                for (int k = 0; k < 6; k++)
                    if (got[k] !== e.len[k]) begin
                        $display("%0t idx %0d len%0d exp %0d got %0d", $time, e.idx, k,
                                 e.len[k], got[k]);
                        errors++;
                    end
                if (o_status !== e.status) begin
                    $display("%0t idx %0d status exp %0d got %0d", $time, e.idx,
                             e.status, o_status);
                    errors++;
                end
                if (o_last_feature !== e.last) begin
                    $display("%0t idx %0d last exp %0d got %0d", $time, e.idx,
                             e.last, o_last_feature);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 3000000) begin
            $display("star_quad_feature_extract: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(int spread);
        if (spread >= 16) return 16'($urandom);
        return 16'($urandom_range(2 ** spread - 1)) - 16'(2 ** (spread - 1));
    endfunction

    task automatic send_frame(int n, int spread);
        for (int i = 0; i < n; i++)
            send_centroid(rand_coord(spread), rand_coord(spread), i == n - 1);
    endtask

    task automatic test_small_frames();
        send_centroid(16'h0000, 16'h0000, 1'b1);
        send_centroid(16'h7FFF, 16'h8000, 1'b0);
        send_centroid(16'h8000, 16'h7FFF, 1'b1);
        send_frame(3, 16);
    endtask

    task automatic test_extremes();
        send_centroid(16'h8000, 16'h8000, 1'b0);
        send_centroid(16'h7FFF, 16'h7FFF, 1'b0);
        send_centroid(16'h8000, 16'h7FFF, 1'b0);
        send_centroid(16'h7FFF, 16'h8000, 1'b0);
        send_centroid(16'hFFFF, 16'h0001, 1'b1);
    endtask

    task automatic test_coincident_and_ties();
        // Every star at one point gives a zero longest length for all.
        for (int i = 0; i < 4; i++) send_centroid(16'h1234, 16'hEDCB, i == 3);
        // A square plus center: equal distances exercise the tie order.
        send_centroid(16'd0, 16'd0, 1'b0);
        send_centroid(16'd100, 16'd0, 1'b0);
        send_centroid(16'd0, 16'd100, 1'b0);
        send_centroid(-16'sd100, 16'd0, 1'b0);
        send_centroid(16'd0, -16'sd100, 1'b1);
    endtask

    task automatic test_overflow();
        send_frame(MAX_STARS + 3, 16);
    endtask

    task automatic test_random(int phases);
        int pct [4] = '{0, 64, 0, 19};
        for (int ph = 0; ph < phases; ph++) begin
            idle_pct = pct[ph % 4];
            send_frame($urandom_range(4, 12), $urandom_range(4, 16));
            send_frame($urandom_range(0, 5), 16);
            send_frame($urandom_range(4, 9), $urandom_range(1, 3));
        end
        idle_pct = 0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_centroid_x = '0;
        i_centroid_y = '0;
        i_last_centroid = 1'b0;
        held_stars = 0;
        dropped_star = 0;
        idle_pct = 0;
        errors = 0;
        cycle_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_small_frames();
        test_extremes();
        test_coincident_and_ties();
        test_overflow();
        test_random(12);
        start <= 1'b0;
        while (pending_features.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && pending_features.size() == 0)
            $display("star_quad_feature_extract: match");
        else
            $display("star_quad_feature_extract: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
